>>> rtl/core/stcew_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment turn cost package
// Shared widths, codes, cell payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package stcew_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int NodeW     = 13;
  localparam int IdxW      = 8;
  localparam int NW        = 7;
  localparam int CfgAw     = 3;
  localparam int DW        = 33;
  localparam int CrdW      = 37;
  localparam int CrdSteps  = 31;
  localparam int LenW      = 33;
  localparam int RadW      = 66;
  localparam int RemW      = 35;
  localparam int AngW      = 18;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [AngW-1:0] ANG_MAX = AngW'(205887);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [CfgAw-1:0] {
    REG_N_POINTS  = 3'd0,
    REG_ROBOT_X   = 3'd1,
    REG_ROBOT_Y   = 3'd2,
    REG_INV_SPEED = 3'd3,
    REG_INV_TURN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                      vld;
    logic                      ld;
    logic [5:0]                slot;
    logic [31:0]               px;
    logic [31:0]               py;
    logic [1:0][NodeW-1:0]     k;
    logic [1:0][IdxW-1:0]      r;
    logic [1:0][NodeW-1:0]     q;
  } div_t;

  typedef struct packed {
    logic                      vld;
    logic                      lk;
    logic [1:0][RadW-1:0]      rad;
    logic [1:0][RemW-1:0]      rem;
    logic [1:0][LenW-1:0]      root;
  } sqrt_t;

  typedef struct packed {
    logic [1:0][CrdW-1:0]      x;
    logic [1:0][CrdW-1:0]      y;
    logic [1:0][31:0]          z;
  } crd_t;

  function automatic logic [31:0] atan_turn(input int unsigned step);
    logic [31:0] t;
    case (step)
      0:       t = 32'h20000000;
      1:       t = 32'h12E4051E;
      2:       t = 32'h09FB385B;
      3:       t = 32'h051111D4;
      4:       t = 32'h028B0D43;
      5:       t = 32'h0145D7E1;
      6:       t = 32'h00A2F61E;
      7:       t = 32'h00517C55;
      8:       t = 32'h0028BE53;
      9:       t = 32'h00145F2F;
      10:      t = 32'h000A2F98;
      11:      t = 32'h000517CC;
      12:      t = 32'h00028BE6;
      13:      t = 32'h000145F3;
      14:      t = 32'h0000A2FA;
      15:      t = 32'h0000517D;
      16:      t = 32'h000028BE;
      17:      t = 32'h0000145F;
      18:      t = 32'h00000A30;
      19:      t = 32'h00000518;
      20:      t = 32'h0000028C;
      21:      t = 32'h00000146;
      22:      t = 32'h000000A3;
      23:      t = 32'h00000051;
      24:      t = 32'h00000029;
      25:      t = 32'h00000014;
      26:      t = 32'h0000000A;
      27:      t = 32'h00000005;
      28:      t = 32'h00000003;
      29, 30:  t = 32'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/stcew_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stcew_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/stcew_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Node decode cell
// One restoring division step for both node codes of an item.
// ----------------------------------------------------------------------------
module stcew_div_cell
  import stcew_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [IdxW-1:0] divisor_i,
  input  wire div_t            cell_i,
  output div_t                 cell_o
);

  div_t            cell_d;
  div_t            cell_q;
  logic [IdxW:0]   t [2];
  logic            ge [2];

  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < 2; l++) begin
      t[l]  = {cell_i.r[l], cell_i.k[l][NodeW-1]};
      ge[l] = t[l] >= {1'b0, divisor_i};
      cell_d.r[l] = ge[l] ? IdxW'(t[l] - {1'b0, divisor_i}) : t[l][IdxW-1:0];
      cell_d.q[l] = {cell_i.q[l][NodeW-2:0], ge[l]};
      cell_d.k[l] = cell_i.k[l] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/stcew_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of the integer square root for both segment lengths.
// ----------------------------------------------------------------------------
module stcew_sqrt_cell
  import stcew_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire sqrt_t cell_i,
  output sqrt_t      cell_o
);

  sqrt_t           cell_d;
  sqrt_t           cell_q;
  logic [RemW+1:0] t  [2];
  logic [RemW+1:0] tr [2];
  logic            ge [2];

  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < 2; l++) begin
      t[l]  = {cell_i.rem[l], cell_i.rad[l][RadW-1 -: 2]};
      tr[l] = (RemW+2)'({cell_i.root[l], 2'b01});
      ge[l] = t[l] >= tr[l];
      cell_d.rem[l]  = ge[l] ? RemW'(t[l] - tr[l]) : RemW'(t[l]);
      cell_d.root[l] = {cell_i.root[l][LenW-2:0], ge[l]};
      cell_d.rad[l]  = cell_i.rad[l] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/stcew_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation for both segment directions.
// ----------------------------------------------------------------------------
module stcew_cordic_cell
  import stcew_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire crd_t cell_i,
  output crd_t      cell_o
);

  crd_t                  cell_d;
  crd_t                  cell_q;
  logic signed [CrdW-1:0] xs [2];
  logic signed [CrdW-1:0] ys [2];

  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < 2; l++) begin
      xs[l] = $signed(cell_i.x[l]) >>> STEP;
      ys[l] = $signed(cell_i.y[l]) >>> STEP;
      if ($signed(cell_i.y[l]) > 0) begin
        cell_d.x[l] = cell_i.x[l] + ys[l];
        cell_d.y[l] = cell_i.y[l] - xs[l];
        cell_d.z[l] = cell_i.z[l] + atan_turn(STEP);
      end else begin
        cell_d.x[l] = cell_i.x[l] - ys[l];
        cell_d.y[l] = cell_i.y[l] + xs[l];
        cell_d.z[l] = cell_i.z[l] - atan_turn(STEP);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/segment_turn_cost_edge_weight.sv
`default_nettype none
// A query result passes through the 13 decode cells, the table read, 37 length
// stages and the two cost stages.
// Throughput: one item per cycle unless the output stalls; a load takes one
// slot and gives no result. The whole pipeline holds while a result waits
// at the output. Reset sets the configuration to its defaults and clears all
// valid flags; point slots stay undefined until loaded, with no clearing pass.
// ----------------------------------------------------------------------------
// Segment turn cost edge weight
// Pipelined edge cost: node decode, point lookup, lengths, headings, cost.
// ----------------------------------------------------------------------------
module segment_turn_cost_edge_weight
  import stcew_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgAw-1:0]  cfg_addr_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic [5:0]        point_index_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic [NodeW-1:0]  from_node_i,
  input  wire logic [NodeW-1:0]  to_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   linked_o,
  output logic [31:0]            cost_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [NW-1:0]   n_points_q;
  logic [31:0]     robot_x_q, robot_y_q, inv_speed_q, inv_turn_q;
  logic [NW-1:0]   n_eff;
  logic [IdxW-1:0] divisor;
  logic            adv, acc;

  div_t            div_in;
  div_t            div_c [NodeW+1];
  div_t            dv;
  logic            link, rob, ram_we;
  logic [63:0]     ram_wdata, rd_a, rd_b, rd_c;

  logic            r_vld_q, r_lk_q, r_rob_q;
  logic [31:0]     sx, sy;
  logic [DW-1:0]   d_q [4];
  logic            d_vld_q, d_lk_q;
  logic [31:0]     mag_q [4];
  logic            s1_vld_q, s1_lk_q;
  logic [63:0]     sq_q [4];
  logic            s2_vld_q, s2_lk_q;
  sqrt_t           s3_d, s3_q;
  sqrt_t           sq_c [LenW+1];

  crd_t            p_d, p_q;
  crd_t            cr_c [CrdSteps+1];
  logic [31:0]     h1_d, h1_q;
  logic [63:0]     h2_prod;
  logic [AngW-1:0] h2_q, ang_d1_q, ang_d2_q, ang_use;

  logic            f1_vld_q, f1_lk_q;
  logic [48:0]     f1_p1_q;
  logic [47:0]     f1_p2_q;
  logic [49:0]     f1_p3_q;
  logic [65:0]     tot;
  logic [31:0]     cost_sat;
  logic            out_valid_q, out_lk_q;
  logic [31:0]     out_cost_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_points_q  <= NW'(1);
      robot_x_q   <= '0;
      robot_y_q   <= '0;
      inv_speed_q <= 32'd65536;
      inv_turn_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_N_POINTS:  n_points_q  <= cfg_wdata_i[NW-1:0];
        REG_ROBOT_X:   robot_x_q   <= cfg_wdata_i;
        REG_ROBOT_Y:   robot_y_q   <= cfg_wdata_i;
        REG_INV_SPEED: inv_speed_q <= cfg_wdata_i;
        REG_INV_TURN:  inv_turn_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = n_points_q;
    if (n_points_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(n_points_q) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end
  end
  assign divisor = {1'b0, n_eff} + IdxW'(1);

  always_comb begin
    div_in      = '0;
    div_in.vld  = acc && (req_type_i == REQ_QUERY);
    div_in.ld   = acc && (req_type_i == REQ_LOAD);
    div_in.slot = point_index_i;
    div_in.px   = point_x_i;
    div_in.py   = point_y_i;
    div_in.k[0] = from_node_i;
    div_in.k[1] = to_node_i;
  end
  assign div_c[0] = div_in;

  for (genvar j = 0; j < NodeW; j++) begin : g_div
    stcew_div_cell u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .divisor_i (divisor),
      .cell_i    (div_c[j]),
      .cell_o    (div_c[j+1])
    );
  end

  assign dv = div_c[NodeW];

  always_comb begin
    link = (dv.q[0] == NodeW'(dv.r[1])) &&
           (NodeW'(dv.r[1]) != dv.q[1]) &&
           (NodeW'(dv.r[0]) != dv.q[0]) &&
           (NodeW'(dv.r[0]) != dv.q[1]) &&
           (dv.q[0] < NodeW'(n_eff)) &&
           (dv.q[1] < NodeW'(n_eff));
    rob    = dv.r[0] == IdxW'(n_eff);
    ram_we = adv && dv.ld && (32'(dv.slot) < MAX_POINTS);
    ram_wdata = {dv.py, dv.px};
  end

  stcew_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram_start (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(AW'(dv.slot)), .wdata_i(ram_wdata),
    .re_i(adv), .raddr_i(AW'(dv.r[0])), .rdata_o(rd_a)
  );
  stcew_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram_mid (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(AW'(dv.slot)), .wdata_i(ram_wdata),
    .re_i(adv), .raddr_i(AW'(dv.q[0])), .rdata_o(rd_b)
  );
  stcew_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram_end (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(AW'(dv.slot)), .wdata_i(ram_wdata),
    .re_i(adv), .raddr_i(AW'(dv.q[1])), .rdata_o(rd_c)
  );

  assign sx = r_rob_q ? robot_x_q : rd_a[31:0];
  assign sy = r_rob_q ? robot_y_q : rd_a[63:32];

  always_comb begin
    s3_d = '0;
    s3_d.vld    = s2_vld_q;
    s3_d.lk     = s2_lk_q;
    s3_d.rad[0] = RadW'({1'b0, sq_q[0]} + {1'b0, sq_q[1]});
    s3_d.rad[1] = RadW'({1'b0, sq_q[2]} + {1'b0, sq_q[3]});
  end
  assign sq_c[0] = s3_q;

  for (genvar j = 0; j < LenW; j++) begin : g_sqrt
    stcew_sqrt_cell u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (sq_c[j]),
      .cell_o (sq_c[j+1])
    );
  end

  always_comb begin
    p_d = '0;
    for (int l = 0; l < 2; l++) begin
      p_d.x[l] = CrdW'($signed(d_q[2*l]));
      p_d.y[l] = CrdW'($signed(d_q[2*l+1]));
      if (d_q[2*l][DW-1]) begin
        p_d.x[l] = -p_d.x[l];
        p_d.y[l] = -p_d.y[l];
        p_d.z[l] = 32'h8000_0000;
      end
    end
  end
  assign cr_c[0] = p_q;

  for (genvar j = 0; j < CrdSteps; j++) begin : g_crd
    stcew_cordic_cell #(.STEP(j)) u_crd (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (cr_c[j]),
      .cell_o (cr_c[j+1])
    );
  end

  always_comb begin
    h1_d = cr_c[CrdSteps].z[1] - cr_c[CrdSteps].z[0];
    if (h1_d > 32'h8000_0000) begin
      h1_d = 32'd0 - h1_d;
    end
  end
  assign h2_prod = 64'(h1_q) * 64'(TWO_PI_Q29) + (64'd1 << 44);

  assign ang_use = (sq_c[LenW].root[0] != '0 && sq_c[LenW].root[1] != '0) ?
                   ang_d2_q : '0;

  assign tot = (66'(f1_p1_q) << 16) + 66'(f1_p2_q) + 66'(f1_p3_q);
  assign cost_sat = (|tot[65:48]) ? 32'hFFFF_FFFF : tot[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q     <= 1'b0;
      r_lk_q      <= 1'b0;
      r_rob_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      d_lk_q      <= 1'b0;
      s1_vld_q    <= 1'b0;
      s1_lk_q     <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_lk_q     <= 1'b0;
      s3_q        <= '0;
      p_q         <= '0;
      f1_vld_q    <= 1'b0;
      f1_lk_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_lk_q    <= 1'b0;
    end else if (adv) begin
      r_vld_q     <= dv.vld;
      r_lk_q      <= dv.vld && link;
      r_rob_q     <= rob;
      d_vld_q     <= r_vld_q;
      d_lk_q      <= r_lk_q;
      s1_vld_q    <= d_vld_q;
      s1_lk_q     <= d_lk_q;
      s2_vld_q    <= s1_vld_q;
      s2_lk_q     <= s1_lk_q;
      s3_q        <= s3_d;
      p_q         <= p_d;
      f1_vld_q    <= sq_c[LenW].vld;
      f1_lk_q     <= sq_c[LenW].lk;
      out_valid_q <= f1_vld_q;
      out_lk_q    <= f1_lk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q[0]     <= {rd_b[31], rd_b[31:0]} - {sx[31], sx};
      d_q[1]     <= {rd_b[63], rd_b[63:32]} - {sy[31], sy};
      d_q[2]     <= {rd_c[31], rd_c[31:0]} - {rd_b[31], rd_b[31:0]};
      d_q[3]     <= {rd_c[63], rd_c[63:32]} - {rd_b[63], rd_b[63:32]};
      for (int v = 0; v < 4; v++) begin
        mag_q[v] <= d_q[v][DW-1] ? 32'(DW'(0) - d_q[v]) : d_q[v][31:0];
        sq_q[v]  <= 64'(mag_q[v]) * 64'(mag_q[v]);
      end
      h1_q       <= h1_d;
      h2_q       <= AngW'(h2_prod >> 45);
      ang_d1_q   <= h2_q;
      ang_d2_q   <= ang_d1_q;
      f1_p1_q    <= 49'(sq_c[LenW].root[1][LenW-1:16]) * 49'(inv_speed_q);
      f1_p2_q    <= 48'(sq_c[LenW].root[1][15:0]) * 48'(inv_speed_q);
      f1_p3_q    <= 50'(ang_use) * 50'(inv_turn_q);
      out_cost_q <= f1_lk_q ? cost_sat : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign linked_o    = out_lk_q;
  assign cost_o      = out_cost_q;

`ifndef ASSERT_OFF
  a_unlinked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !linked_o |-> cost_o == '0)
    else $error("Unlinked result carries a nonzero cost.");
  a_link_is_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_lk_q |-> r_vld_q)
    else $error("Link flag set for a stage without a query.");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(f1_vld_q) && $stable(f1_lk_q))
    else $error("Pipeline moved while the output was stalled.");
  a_load_query_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv.vld |-> !dv.ld)
    else $error("A decode stage holds both a load and a query.");
`endif

endmodule
`default_nettype wire

>>> test/stcew_checker.sv
// ----------------------------------------------------------------------------
// Segment turn cost edge weight checker
// Watches the configuration port and both channels, predicts each query
// result from its own copy of the point table and registers, and compares
// every result transfer with the oldest expected edge weight.
// ----------------------------------------------------------------------------
module stcew_checker
  import stcew_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgAw-1:0]  cfg_addr_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              req_type_i,
  input  logic [5:0]        point_index_i,
  input  logic [31:0]       point_x_i,
  input  logic [31:0]       point_y_i,
  input  logic [NodeW-1:0]  from_node_i,
  input  logic [NodeW-1:0]  to_node_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              linked_i,
  input  logic [31:0]       cost_i,
  output int                pending_o,
  output int                errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit          linked;
    logic [31:0] cost;
  } edge_weight_t;

  localparam bit [31:0] TURN_STEP [31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  logic [31:0]  px_tab [64];
  logic [31:0]  py_tab [64];
  logic [6:0]   n_points;
  logic [31:0]  robot_x, robot_y, inv_speed, inv_turn;
  edge_weight_t weight_q [$];
  int           errors;

  assign pending_o = weight_q.size();
  assign errors_o  = errors;

  function automatic longint unsigned seg_length(longint dx, longint dy);
    logic [65:0] ux, uy, s;
    logic [35:0] rem;
    logic [35:0] trial;
    logic [33:0] root;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    s = ux * ux + uy * uy;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | s[2*k +: 2];
      trial = {root, 2'b01};
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic bit [31:0] heading(longint x, longint y);
    bit [31:0] z;
    longint xs, ys;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + TURN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - TURN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic edge_weight_t edge_weight(logic [NodeW-1:0] from_code,
                                               logic [NodeW-1:0] to_code);
    edge_weight_t w;
    int n, a1, b1, a2, b2;
    longint sx, sy, ex, ey, qx, qy;
    longint unsigned len1, len2, ang, ai, af, bi, bf, sum;
    bit [31:0] d;
    w.linked = 1'b0;
    w.cost = '0;
    n = n_points;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    a1 = from_code % (n + 1);
    b1 = from_code / (n + 1);
    a2 = to_code % (n + 1);
    b2 = to_code / (n + 1);
    if (!(b1 == a2 && a2 != b2 && a1 != b1 && a1 != b2 && b1 < n && b2 < n))
      return w;
    if (a1 == n) begin
      sx = longint'($signed(robot_x));
      sy = longint'($signed(robot_y));
    end else begin
      sx = longint'($signed(px_tab[a1]));
      sy = longint'($signed(py_tab[a1]));
    end
    ex = longint'($signed(px_tab[b1]));
    ey = longint'($signed(py_tab[b1]));
    qx = longint'($signed(px_tab[b2]));
    qy = longint'($signed(py_tab[b2]));
    len1 = seg_length(ex - sx, ey - sy);
    len2 = seg_length(qx - ex, qy - ey);
    ang = 0;
    if (len1 != 0 && len2 != 0) begin
      d = heading(qx - ex, qy - ey) - heading(ex - sx, ey - sy);
      if (d > 32'h80000000) d = 32'd0 - d;
      ang = (longint'(d) * longint'(TWO_PI_Q29) + (64'd1 << 44)) >> 45;
    end
    af = len2 * inv_speed[15:0];
    ai = len2 * inv_speed[31:16] + (af >> 16);
    af = af & 64'hFFFF;
    bf = ang * inv_turn[15:0];
    bi = ang * inv_turn[31:16] + (bf >> 16);
    bf = bf & 64'hFFFF;
    sum = ai + bi + ((af + bf) >> 16);
    if (sum > 64'hFFFFFFFF) sum = 64'hFFFFFFFF;
    w.linked = 1'b1;
    w.cost = sum[31:0];
    return w;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_weight_t w;
    if (!rst_ni) begin
      n_points <= 7'd1;
      robot_x <= '0;
      robot_y <= '0;
      inv_speed <= 32'd65536;
      inv_turn <= 32'd65536;
      weight_q.delete();
      errors = 0;
      for (int i = 0; i < 64; i++) begin
        px_tab[i] <= '0;
        py_tab[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_N_POINTS:  n_points <= cfg_wdata_i[6:0];
          REG_ROBOT_X:   robot_x <= cfg_wdata_i;
          REG_ROBOT_Y:   robot_y <= cfg_wdata_i;
          REG_INV_SPEED: inv_speed <= cfg_wdata_i;
          REG_INV_TURN:  inv_turn <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (req_e'(req_type_i) == REQ_LOAD) begin
          px_tab[point_index_i] <= point_x_i;
          py_tab[point_index_i] <= point_y_i;
        end else begin
          weight_q.push_back(edge_weight(from_node_i, to_node_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (weight_q.size() == 0) begin
          report("unexpected result, linked", 32'(linked_i), 32'd0);
        end else begin
          w = weight_q.pop_front();
          if (linked_i !== w.linked) report("linked", 32'(linked_i), 32'(w.linked));
          if (cost_i !== w.cost) report("cost", cost_i, w.cost);
        end
      end
    end
  end

endmodule

>>> test/segment_turn_cost_edge_weight_tb.sv
// ----------------------------------------------------------------------------
// Segment turn cost edge weight testbench
// Loads the point table, steps through several register settings and sends
// directed and random edge queries with bursty input and a stalling output,
// while the checker compares every result with its own prediction.
// ----------------------------------------------------------------------------
module segment_turn_cost_edge_weight_tb;
  import stcew_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgAw-1:0]  cfg_addr_i = '0;
  logic [31:0]       cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              req_type_i = 1'b0;
  logic [5:0]        point_index_i = '0;
  logic [31:0]       point_x_i = '0;
  logic [31:0]       point_y_i = '0;
  logic [NodeW-1:0]  from_node_i = '0;
  logic [NodeW-1:0]  to_node_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              linked_o;
  logic [31:0]       cost_o;
  int                pending, errors;
  int                burst_left = 0;
  bit                no_gaps = 1'b0;
  bit                hold_req = 1'b0;
  int                cur_n = 1;

  always #2 clk_i = ~clk_i;

  segment_turn_cost_edge_weight DUT (.*);

  stcew_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .point_index_i,
    .point_x_i, .point_y_i, .from_node_i, .to_node_i,
    .out_valid_i(out_valid_o), .out_ready_i, .linked_i(linked_o), .cost_i(cost_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stall pattern, with a long hold-off on request.
  always @(posedge clk_i) begin
    int hold;
    if (hold_req) begin
      hold = 400;
      hold_req = 1'b0;
      while (hold > 0) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
        hold--;
      end
    end
    case ($urandom_range(0, 3))
      0: out_ready_i <= ($urandom_range(0, 3) != 0);
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= 1'b1;
    endcase
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send(req_e kind, logic [5:0] slot, logic [31:0] x, logic [31:0] y,
                      logic [NodeW-1:0] f, logic [NodeW-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    point_index_i <= slot;
    point_x_i <= x;
    point_y_i <= y;
    from_node_i <= f;
    to_node_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic load(logic [5:0] slot, logic [31:0] x, logic [31:0] y);
    send(REQ_LOAD, slot, x, y, NodeW'($urandom), NodeW'($urandom));
  endtask

  task automatic query(logic [NodeW-1:0] f, logic [NodeW-1:0] t);
    send(REQ_QUERY, 6'($urandom), $urandom, $urandom, f, t);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(logic [6:0] n, logic [31:0] rx, logic [31:0] ry,
                       logic [31:0] vs, logic [31:0] vt);
    settle();
    write_reg(REG_N_POINTS, 32'(n));
    write_reg(REG_ROBOT_X, rx);
    write_reg(REG_ROBOT_Y, ry);
    write_reg(REG_INV_SPEED, vs);
    write_reg(REG_INV_TURN, vt);
    cur_n = (n < 1) ? 1 : (n > 64) ? 64 : n;
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 400)) << 16 : 32'd0;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic well_formed();
    int a1, b1, b2;
    a1 = $urandom_range(0, cur_n);
    b1 = $urandom_range(0, cur_n - 1);
    b2 = $urandom_range(0, cur_n - 1);
    query(NodeW'(a1 + b1 * (cur_n + 1)), NodeW'(b1 + b2 * (cur_n + 1)));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: load(6'($urandom), coord(), coord());
        1: query(NodeW'($urandom), NodeW'($urandom));
        2: query(NodeW'($urandom_range(0, 4159)), NodeW'($urandom_range(0, 4159)));
        default: well_formed();
      endcase
    end
  endtask

  initial begin
    logic [31:0] rx, ry;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < 64; s++) load(6'(s), coord(), coord());
    load(6'd0, 32'h80000000, 32'h80000000);
    load(6'd1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    load(6'd2, 32'h7FFFFFFF, 32'h7FFFFFFF);
    load(6'd3, 32'h00010000, 32'h00000000);
    load(6'd4, 32'h00020000, 32'h00000000);
    load(6'd5, 32'h00000000, 32'h00000000);

    // Directed: robot start, extremes, coincident points, straight and reversed
    // turns, malformed codes, first with the widest point count, then with 1, 0 and 100.
    setup(7'd64, 32'h0, 32'h0, 32'h00010000, 32'h00010000);
    query(NodeW'(64 + 0 * 65), NodeW'(0 + 1 * 65));
    query(NodeW'(0 + 1 * 65), NodeW'(1 + 2 * 65));
    query(NodeW'(5 + 3 * 65), NodeW'(3 + 4 * 65));
    query(NodeW'(4 + 3 * 65), NodeW'(3 + 5 * 65));
    query(NodeW'(64 + 5 * 65), NodeW'(5 + 3 * 65));
    query(NodeW'(3 + 3 * 65), NodeW'(3 + 4 * 65));
    query(NodeW'(4 + 3 * 65), NodeW'(3 + 4 * 65));
    query(NodeW'(0 + 64 * 65), NodeW'(64 + 1 * 65));
    query(NodeW'(8191), NodeW'(8191));
    query(NodeW'(0), NodeW'(0));
    setup(7'd64, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    query(NodeW'(64 + 1 * 65), NodeW'(1 + 0 * 65));
    query(NodeW'(64 + 3 * 65), NodeW'(3 + 4 * 65));
    setup(7'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    query(NodeW'(1), NodeW'(0));
    query(NodeW'(8191), NodeW'(2));
    setup(7'd0, 32'h0, 32'h0, 32'h0, 32'h00010000);
    query(NodeW'(1), NodeW'(2));
    setup(7'd100, 32'h00030000, 32'h0, 32'h00010000, 32'h0);
    query(NodeW'(64 + 4 * 65), NodeW'(4 + 3 * 65));

    for (int ph = 0; ph < 10; ph++) begin
      rx = coord();
      ry = coord();
      case (ph)
        0: setup(7'd64, rx, ry, 32'h00010000, 32'h00010000);
        1: setup(7'd2, rx, ry, 32'hFFFFFFFF, 32'h0);
        2: setup(7'd127, rx, ry, $urandom, $urandom);
        3: setup(7'd3, rx, ry, 32'h0, 32'hFFFFFFFF);
        default: setup(7'($urandom_range(1, 64)), rx, ry, $urandom, $urandom);
      endcase
      if (ph == 4) begin
        no_gaps = 1'b1;
        hold_req = 1'b1;
      end
      random_phase(100);
      no_gaps = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/stcew_pkg.sv
rtl/core/stcew_ram.sv
rtl/core/stcew_div_cell.sv
rtl/core/stcew_sqrt_cell.sv
rtl/core/stcew_cordic_cell.sv
rtl/core/segment_turn_cost_edge_weight.sv
test/stcew_checker.sv
test/segment_turn_cost_edge_weight_tb.sv
